>>> sv/led_matrix_bitplane_scanner_core_macros.svh
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner - assertion macros
// Shared property forms; clk and rst_n are taken from the including module.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_BITPLANE_SCANNER_CORE_MACROS_SVH
`define LED_MATRIX_BITPLANE_SCANNER_CORE_MACROS_SVH

// same-cycle implication
`define LMBS_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmbs: same-cycle check failed");

// next-cycle implication
`define LMBS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmbs: next-cycle check failed");

`endif

>>> sv/lmbs_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner - package
// Shared constants, register codes and the per-tick control struct.
// ----------------------------------------------------------------------------
package lmbs_pkg;

    localparam int PANEL_WIDTH_DEF  = 32;
    localparam int PANEL_HEIGHT_DEF = 32;
    localparam int COLOR_PLANES_DEF = 8;
    localparam int STORE_DEPTH      = PANEL_WIDTH_DEF * PANEL_HEIGHT_DEF;

    localparam int COLOR_W    = 24;
    localparam int PIX_ADDR_W = 10;
    localparam int WAIT_W     = 10;
    localparam int DWELL_W    = 17;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [WAIT_W-1:0] BASE_WAIT_RESET = 10'd5;

    // register index, taken from paddr word bit
    localparam logic REG_BASE_WAIT = 1'b0;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic [3:0] row_address;
        logic [2:0] plane;
        logic       shift;
        logic       latch;
        logic       lit;
        logic       frame_done;
    } tick_ctl_t;

endpackage

>>> sv/lmbs_frame_mem.sv
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner - frame store
// One write port, two registered read ports; zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module lmbs_frame_mem
    import lmbs_pkg::*;
#(
    parameter int DEPTH = STORE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [COLOR_W-1:0]       wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_up,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_lo,
    output logic [COLOR_W-1:0]       rd_data_up,
    output logic [COLOR_W-1:0]       rd_data_lo,
    output logic                     busy
);

    localparam int AW = $clog2(DEPTH);

    logic [COLOR_W-1:0] mem [DEPTH];

    logic               clr_busy_reg;
    logic               clr_busy_next;
    logic [AW-1:0]      clr_addr_reg;
    logic [AW-1:0]      clr_addr_next;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [COLOR_W-1:0] mem_wd;
    logic [COLOR_W-1:0] rd_up_reg;
    logic [COLOR_W-1:0] rd_lo_reg;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign mem_we = clr_busy_reg || wr_en;
    assign mem_wa = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign mem_wd = clr_busy_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_up_reg <= mem[rd_addr_up];
            rd_lo_reg <= mem[rd_addr_lo];
        end
    end

    assign rd_data_up = rd_up_reg;
    assign rd_data_lo = rd_lo_reg;
    assign busy       = clr_busy_reg;

endmodule

>>> sv/lmbs_scan.sv
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner - scan sequencer
// Row, plane, column and dwell counters; shift / latch / lit phases.
// ----------------------------------------------------------------------------
`include "led_matrix_bitplane_scanner_core_macros.svh"

module lmbs_scan
    import lmbs_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
    parameter int COLOR_PLANES = COLOR_PLANES_DEF
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          advance,
    input  logic [WAIT_W-1:0]                             base_wait,
    output tick_ctl_t                                     ctl,
    output logic [$clog2(PANEL_WIDTH*PANEL_HEIGHT)-1:0]   up_addr,
    output logic [$clog2(PANEL_WIDTH*PANEL_HEIGHT)-1:0]   lo_addr
);

    localparam int ROW_PAIRS = PANEL_HEIGHT / 2;
    localparam int AW        = $clog2(PANEL_WIDTH * PANEL_HEIGHT);
    localparam int RW        = $clog2(ROW_PAIRS);
    localparam int CW        = $clog2(PANEL_WIDTH);
    localparam int PW        = (COLOR_PLANES > 1) ? $clog2(COLOR_PLANES) : 1;

    typedef enum logic [1:0] {
        PH_SHIFT = 2'd0,
        PH_LATCH = 2'd1,
        PH_LIT   = 2'd2
    } phase_t;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [RW-1:0]        row_reg;
    logic [RW-1:0]        row_next;
    logic [PW-1:0]        plane_reg;
    logic [PW-1:0]        plane_next;
    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        col_next;
    logic [DWELL_W-1:0]   dwell_reg;
    logic [DWELL_W-1:0]   dwell_next;

    logic [WAIT_W-1:0]    bw;
    logic [DWELL_W-1:0]   wait_len;
    logic [DWELL_W-1:0]   dwell_inc;
    logic [CW:0]          col_inc;
    logic [RW+3:0]        row_ext;
    logic                 last_plane;
    logic                 last_row;

    assign bw         = (base_wait == '0) ? WAIT_W'(1) : base_wait;
    assign row_ext    = (RW + 4)'(row_reg);
    assign last_plane = (plane_reg == PW'(COLOR_PLANES - 1));
    assign last_row   = (row_reg == RW'(ROW_PAIRS - 1));
    assign dwell_inc  = dwell_reg + 1'b1;
    assign col_inc    = (CW + 1)'(col_reg) + 1'b1;

    always_comb
    begin
        ctl             = '0;
        ctl.row_address = row_ext[3:0];
        ctl.plane       = 3'(plane_reg);
        wait_len        = DWELL_W'(bw) << ctl.plane;

        phase_next = phase_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        col_next   = col_reg;
        dwell_next = dwell_reg;

        case (phase_reg)
            PH_LATCH:
            begin
                ctl.latch  = 1'b1;
                phase_next = PH_LIT;
                dwell_next = '0;
            end
            PH_LIT:
            begin
                ctl.lit    = 1'b1;
                dwell_next = dwell_inc;
                if (dwell_inc >= wait_len)
                begin
                    ctl.frame_done = last_plane && last_row;
                    phase_next     = PH_SHIFT;
                    dwell_next     = '0;
                    if (last_plane)
                    begin
                        plane_next = '0;
                        row_next   = last_row ? '0 : row_reg + 1'b1;
                    end
                    else
                    begin
                        plane_next = plane_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                ctl.shift  = 1'b1;
                phase_next = PH_SHIFT;
                col_next   = col_inc[CW-1:0];
                if (col_inc >= (CW + 1)'(PANEL_WIDTH))
                begin
                    col_next   = '0;
                    phase_next = PH_LATCH;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SHIFT;
            row_reg   <= '0;
            plane_reg <= '0;
            col_reg   <= '0;
            dwell_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            plane_reg <= plane_next;
            col_reg   <= col_next;
            dwell_reg <= dwell_next;
        end
    end

    assign up_addr = AW'(AW'(row_reg) * AW'(PANEL_WIDTH)) + AW'(col_reg);
    assign lo_addr = up_addr + AW'(ROW_PAIRS * PANEL_WIDTH);

    `LMBS_ASSERT_NEXT(a_latch_then_lit, advance && phase_reg == PH_LATCH, phase_reg == PH_LIT)
    `LMBS_ASSERT_IMPLIES(a_line_complete, phase_reg != PH_SHIFT, col_reg == '0)
    `LMBS_ASSERT_IMPLIES(a_plane_range, 1'b1, 32'(plane_reg) < 32'(COLOR_PLANES))

endmodule

>>> sv/led_matrix_bitplane_scanner_core.sv
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner - top level
// Takes one item per clock while item_stall is low. A pixel-write item stores
// a 24-bit colour at an in-range address and gives no result; a tick item
// gives one set of panel pin levels through the frame store read register,
// then the output register, so ticks stream back to back at one per cycle
// while nothing stalls; each item uses the single write port or the two read
// ports of the frame store at most once. The output register and the read
// stage together let one item enter while a result is held by result_stall.
// After reset the frame store is zero-filled, one pixel per cycle, while
// item_stall stays high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`include "led_matrix_bitplane_scanner_core_macros.svh"

module led_matrix_bitplane_scanner_core
    import lmbs_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
    parameter int COLOR_PLANES = COLOR_PLANES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  command,
    input  logic [PIX_ADDR_W-1:0] pixel_address,
    input  logic [COLOR_W-1:0]    pixel_color,

    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [3:0]            row_address,
    output logic                  upper_red,
    output logic                  upper_green,
    output logic                  upper_blue,
    output logic                  lower_red,
    output logic                  lower_green,
    output logic                  lower_blue,
    output logic                  shift_clock,
    output logic                  latch,
    output logic                  display_enable,
    output logic                  frame_done
);

    localparam int STORE_SIZE = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int AW         = $clog2(STORE_SIZE);

    // configuration
    logic [WAIT_W-1:0]  base_wait_reg;
    logic               cfg_write;

    // front end
    logic               accept;
    logic               tick;
    logic               wr_en;
    logic               in_range;
    logic [AW+9:0]      wr_addr_ext;
    logic               mem_busy;
    tick_ctl_t          scan_ctl;
    logic [AW-1:0]      up_addr;
    logic [AW-1:0]      lo_addr;
    logic [COLOR_W-1:0] rd_up;
    logic [COLOR_W-1:0] rd_lo;

    // read stage and output register
    logic               s1_valid_reg;
    logic               s1_valid_next;
    tick_ctl_t          s1_ctl_reg;
    logic               s1_adv;
    logic               s1_free;
    logic [2:0]         bit_sel;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [3:0]         row_address_reg;
    logic [5:0]         colour_reg;
    logic [5:0]         colour_next;
    logic [3:0]         strobe_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_wait_reg <= BASE_WAIT_RESET;
        end
        else if (cfg_write && paddr[2] == REG_BASE_WAIT)
        begin
            base_wait_reg <= pwdata[WAIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BASE_WAIT) ? CFG_DATA_W'(base_wait_reg) : '0;

    assign s1_adv     = !out_valid_reg || !result_stall;
    assign s1_free    = !s1_valid_reg || s1_adv;
    assign item_stall = mem_busy || !s1_free;
    assign accept     = item_valid && !item_stall;
    assign tick       = accept && (command == CMD_TICK);
    assign in_range   = 32'(pixel_address) < 32'(STORE_SIZE);
    assign wr_en      = accept && (command == CMD_WRITE) && in_range;
    assign wr_addr_ext = (AW + 10)'(pixel_address);

    lmbs_scan #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .COLOR_PLANES (COLOR_PLANES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (tick),
        .base_wait (base_wait_reg),
        .ctl       (scan_ctl),
        .up_addr   (up_addr),
        .lo_addr   (lo_addr)
    );

    lmbs_frame_mem #(
        .DEPTH (STORE_SIZE)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr_ext[AW-1:0]),
        .wr_data    (pixel_color),
        .rd_en      (tick && scan_ctl.shift),
        .rd_addr_up (up_addr),
        .rd_addr_lo (lo_addr),
        .rd_data_up (rd_up),
        .rd_data_lo (rd_lo),
        .busy       (mem_busy)
    );

    // plane bit within each colour byte
    assign bit_sel = 3'(8 - COLOR_PLANES) + s1_ctl_reg.plane;

    always_comb
    begin
        s1_valid_next  = s1_free ? tick : s1_valid_reg;
        out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;
        colour_next    = '0;
        if (s1_ctl_reg.shift)
        begin
            colour_next = {rd_lo[{2'd2, bit_sel}], rd_lo[{2'd1, bit_sel}],
                           rd_lo[{2'd0, bit_sel}], rd_up[{2'd2, bit_sel}],
                           rd_up[{2'd1, bit_sel}], rd_up[{2'd0, bit_sel}]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            s1_ctl_reg <= scan_ctl;
        end
        if (s1_adv && s1_valid_reg)
        begin
            row_address_reg <= s1_ctl_reg.row_address;
            colour_reg      <= colour_next;
            strobe_reg      <= {s1_ctl_reg.shift, s1_ctl_reg.latch,
                                s1_ctl_reg.lit, s1_ctl_reg.frame_done};
        end
    end

    assign result_valid   = out_valid_reg;
    assign row_address    = row_address_reg;
    assign upper_red      = colour_reg[0];
    assign upper_green    = colour_reg[1];
    assign upper_blue     = colour_reg[2];
    assign lower_red      = colour_reg[3];
    assign lower_green    = colour_reg[4];
    assign lower_blue     = colour_reg[5];
    assign shift_clock    = strobe_reg[3];
    assign latch          = strobe_reg[2];
    assign display_enable = strobe_reg[1];
    assign frame_done     = strobe_reg[0];

    `LMBS_ASSERT_IMPLIES(a_one_strobe, result_valid, $onehot({shift_clock, latch, display_enable}))
    `LMBS_ASSERT_IMPLIES(a_dark_off_shift, result_valid && !shift_clock, colour_reg == '0)
    `LMBS_ASSERT_IMPLIES(a_done_when_lit, result_valid && frame_done, display_enable)
    `LMBS_ASSERT_IMPLIES(a_empty_in_clear, mem_busy, !s1_valid_reg && !out_valid_reg)

endmodule
